[rtl/gld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gld_pkg;

	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int TABLE_DEPTH_DEF   = 4096;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_PIXEL   = 3'd0,
		ST_NEED    = 3'd1,
		ST_TAKEN   = 3'd2,
		ST_REFUSED = 3'd3,
		ST_END     = 3'd4,
		ST_EXTRA   = 3'd5,
		ST_EARLY   = 3'd6
	} status_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_MIN_SIZE = 2'd0;
	localparam logic [1:0] REG_WIDTH    = 2'd1;
	localparam logic [1:0] REG_HEIGHT   = 2'd2;

	localparam logic OP_PULL = 1'b1;

	// One queued input word after classification.
	typedef struct packed {
		logic       is_pull;
		logic [7:0] data_byte;
	} item_t;

	// Effective LZW minimum code size after saturation.
	function automatic logic [3:0] eff_min(input logic [3:0] m_in, input int mcb,
			input int depth);
		logic [3:0] m;
		m = m_in;
		if (m < 4'd2) m = 4'd2;
		if (m > 4'd9) m = 4'd9;
		if (int'(m) > mcb - 1) m = 4'(mcb - 1);
		for (int i = 0; i < 8; i++) begin
			if (m > 4'd2 && ((1 << m) + 2) > depth) m = m - 4'd1;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

[rtl/gld_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module gld_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire              op,
	input  wire  [7:0]       data_byte,
	output logic             q_valid,
	output gld_pkg::item_t   q_item,
	input  wire              q_take
);
	import gld_pkg::*;

	item_t       ent_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        wr_en;

	assign in_stall = (cnt_q == 2'd2);
	assign wr_en    = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wp_q] <= '{is_pull: (op == OP_PULL), data_byte: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (q_take) rp_q <= ~rp_q;
			unique case ({wr_en, q_take})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> cnt_q != 2'd0) else $error("queue read while empty");

endmodule
`default_nettype wire

[rtl/gld_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module gld_core #(
	parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
	parameter int TABLE_DEPTH   = gld_pkg::TABLE_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              q_valid,
	input  gld_pkg::item_t   q_item,
	output logic             q_take,
	input  wire              cfg_valid,
	input  wire  [1:0]       cfg_index,
	input  wire  [15:0]      cfg_data,
	output logic             res_valid,
	input  wire              res_stall,
	output logic [2:0]       status,
	output logic [7:0]       pixel,
	output logic [15:0]      pos_x,
	output logic [15:0]      pos_y,
	output logic             string_last,
	output logic [15:0]      bad_codes
);
	import gld_pkg::*;

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int SW   = AW + 1;
	localparam int MCB  = MAX_CODE_BITS;
	localparam int CMPW = (SW > MCB + 1) ? SW : MCB + 1;
	localparam logic [3:0] RST_M = eff_min(4'd8, MAX_CODE_BITS, TABLE_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_LOOP, S_WCHK, S_WDATA, S_POPD} state_t;

	state_t         st_q;
	logic [3:0]     min_q, effm_q, cw_q;
	logic [15:0]    width_q, height_q, col_q, row_q, bad_q;
	logic [SW-1:0]  sc_q, ns_q, ns_inc;
	logic [MCB-1:0] old_q, code_q, c_q;
	logic [7:0]     fc_q, bbl_q;
	logic [23:0]    buf_q;
	logic [4:0]     bc_q;
	logic           ac_q, de_q, es_q, fail_q;

	logic           res_valid_q, res_last_q;
	status_t        res_status_q;
	logic [7:0]     res_pixel_q;
	logic [15:0]    res_x_q, res_y_q, res_bad_q;

	logic [7:0]     stk_mem [TABLE_DEPTH];
	logic [7:0]     sfx_mem [TABLE_DEPTH];
	logic [MCB-1:0] pfx_mem [TABLE_DEPTH];
	logic [7:0]     stk_rd_q, sfx_rd_q;
	logic [MCB-1:0] pfx_rd_q;

	logic [MCB-1:0] clear_c, end_c, newc_c, cmask, ccode, c_ac, code_sel;
	logic [CMPW-1:0] pow_c;
	logic           bits_ok, high, over, is_clear, is_end, walk_more, tab_add;
	logic           oready, row_full, push_en, walk_rd, pop_rd, tab_we;
	logic [7:0]     push_d;
	logic [SW-1:0]  sc_dec;
	logic [3:0]     m_new;
	logic [15:0]    col_n;

	assign oready   = !res_valid_q || !res_stall;
	assign q_take   = (st_q == S_IDLE) && q_valid && oready && !cfg_valid;
	assign row_full = (row_q == height_q);
	assign sc_dec   = sc_q - SW'(1);
	assign col_n    = col_q + 16'd1;
	assign m_new    = (cfg_index == REG_MIN_SIZE) ?
		eff_min(cfg_data[3:0], MAX_CODE_BITS, TABLE_DEPTH) : effm_q;

	assign clear_c  = MCB'(1) << effm_q;
	assign end_c    = clear_c + MCB'(1);
	assign newc_c   = clear_c + MCB'(2);
	assign cmask    = (MCB'(1) << cw_q) - MCB'(1);
	assign ccode    = buf_q[MCB-1:0] & cmask;
	assign pow_c    = CMPW'(1) << cw_q;
	assign bits_ok  = bc_q >= {1'b0, cw_q};
	assign high     = CMPW'(ccode) >= CMPW'(ns_q);
	assign over     = CMPW'(ccode) > CMPW'(ns_q);
	assign is_clear = (ccode == clear_c);
	assign is_end   = (ccode == end_c);
	assign c_ac     = high ? '0 : ccode;
	assign code_sel = high ? old_q : ccode;
	assign walk_more = (CMPW'(code_q) >= CMPW'(newc_c)) && (sc_q < SW'(TABLE_DEPTH - 1));
	assign tab_add  = (CMPW'(ns_q) < pow_c) && (ns_q < SW'(TABLE_DEPTH));
	assign ns_inc   = tab_add ? ns_q + SW'(1) : ns_q;

	always_comb begin
		push_en = 1'b0;
		push_d  = fc_q;
		walk_rd = 1'b0;
		pop_rd  = 1'b0;
		tab_we  = 1'b0;
		unique case (st_q)
			S_LOOP: begin
				if (sc_q != '0) begin
					pop_rd = !row_full;
				end else if (!es_q && bits_ok && !is_clear && !is_end && (ac_q || high)) begin
					push_en = 1'b1;
					push_d  = ac_q ? c_ac[7:0] : fc_q;
				end
			end
			S_WCHK: begin
				if (walk_more) begin
					walk_rd = 1'b1;
				end else begin
					push_en = 1'b1;
					push_d  = code_q[7:0];
					tab_we  = tab_add;
				end
			end
			S_WDATA: begin
				push_en = 1'b1;
				push_d  = sfx_rd_q;
			end
			default: ;
		endcase
		if (sc_q >= SW'(TABLE_DEPTH)) push_en = 1'b0;
		if (cfg_valid) begin
			push_en = 1'b0;
			tab_we  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) stk_mem[sc_q[AW-1:0]] <= push_d;
		if (pop_rd) stk_rd_q <= stk_mem[sc_dec[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			sfx_mem[ns_q[AW-1:0]] <= code_q[7:0];
			pfx_mem[ns_q[AW-1:0]] <= old_q;
		end
		if (walk_rd) begin
			sfx_rd_q <= sfx_mem[AW'(code_q)];
			pfx_rd_q <= pfx_mem[AW'(code_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			min_q <= 4'd8; effm_q <= RST_M; width_q <= 16'd1; height_q <= 16'd1;
			sc_q <= '0; ns_q <= SW'((1 << RST_M) + 2); cw_q <= RST_M + 4'd1;
			old_q <= '0; fc_q <= '0; buf_q <= '0; bc_q <= '0; bbl_q <= '0;
			ac_q <= 1'b0; de_q <= 1'b0; es_q <= 1'b0; fail_q <= 1'b0;
			col_q <= '0; row_q <= '0; bad_q <= '0;
			code_q <= '0; c_q <= '0;
			res_valid_q <= 1'b0; res_status_q <= ST_PIXEL; res_pixel_q <= '0;
			res_x_q <= '0; res_y_q <= '0; res_last_q <= 1'b0; res_bad_q <= '0;
		end else begin
			if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index != 2'd3) begin
					unique case (cfg_index)
						REG_MIN_SIZE: min_q    <= cfg_data[3:0];
						REG_WIDTH:    width_q  <= cfg_data;
						default:      height_q <= cfg_data;
					endcase
					effm_q <= m_new;
					sc_q <= '0; ns_q <= SW'(MCB'(1) << m_new) + SW'(2);
					cw_q <= m_new + 4'd1;
					old_q <= '0; fc_q <= '0; buf_q <= '0; bc_q <= '0; bbl_q <= '0;
					ac_q <= 1'b0; de_q <= 1'b0; es_q <= 1'b0; fail_q <= 1'b0;
					col_q <= '0; row_q <= '0; bad_q <= '0;
				end
				st_q <= S_IDLE;
			end else begin
				if (push_en) sc_q <= sc_q + SW'(1);
				unique case (st_q)
					S_IDLE: begin
						if (q_take) begin
							res_pixel_q <= '0;
							res_last_q  <= 1'b0;
							res_x_q     <= col_q;
							res_y_q     <= row_q;
							res_bad_q   <= bad_q;
							if (!q_item.is_pull) begin
								res_valid_q <= 1'b1;
								priority if (fail_q || es_q || de_q) begin
									res_status_q <= ST_REFUSED;
								end else if (bbl_q == 8'd0) begin
									if (q_item.data_byte == 8'd0) de_q <= 1'b1;
									else bbl_q <= q_item.data_byte;
									res_status_q <= ST_TAKEN;
								end else if (bc_q > 5'd16) begin
									res_status_q <= ST_REFUSED;
								end else begin
									buf_q <= buf_q | (24'(q_item.data_byte) << bc_q);
									bc_q  <= bc_q + 5'd8;
									bbl_q <= bbl_q - 8'd1;
									res_status_q <= ST_TAKEN;
								end
							end else if (fail_q) begin
								res_valid_q  <= 1'b1;
								res_status_q <= ST_EXTRA;
							end else begin
								st_q <= S_LOOP;
							end
						end
					end
					S_LOOP: begin
						res_pixel_q <= '0;
						res_last_q  <= 1'b0;
						res_x_q     <= col_q;
						res_y_q     <= row_q;
						res_bad_q   <= bad_q;
						priority if (sc_q != '0) begin
							if (row_full) begin
								fail_q       <= 1'b1;
								res_valid_q  <= 1'b1;
								res_status_q <= ST_EXTRA;
								st_q         <= S_IDLE;
							end else begin
								sc_q <= sc_dec;
								st_q <= S_POPD;
							end
						end else if (es_q) begin
							res_valid_q  <= 1'b1;
							res_status_q <= ST_END;
							st_q         <= S_IDLE;
						end else if (!bits_ok) begin
							res_valid_q  <= 1'b1;
							res_status_q <= de_q ? ST_EARLY : ST_NEED;
							st_q         <= S_IDLE;
						end else begin
							buf_q <= buf_q >> cw_q;
							bc_q  <= bc_q - {1'b0, cw_q};
							priority if (is_clear) begin
								cw_q <= effm_q + 4'd1;
								ns_q <= SW'(newc_c);
								ac_q <= 1'b1;
							end else if (is_end) begin
								es_q <= 1'b1;
							end else if (ac_q) begin
								ac_q  <= 1'b0;
								old_q <= c_ac;
								fc_q  <= c_ac[7:0];
							end else begin
								if (over && bad_q != 16'hFFFF) bad_q <= bad_q + 16'd1;
								code_q <= code_sel;
								c_q    <= ccode;
								st_q   <= S_WCHK;
							end
						end
					end
					S_WCHK: begin
						if (walk_more) begin
							st_q <= S_WDATA;
						end else begin
							if (tab_add) begin
								fc_q  <= code_q[7:0];
								old_q <= c_q;
								ns_q  <= ns_inc;
							end
							if (CMPW'(ns_inc) >= pow_c && cw_q < 4'(MCB)) cw_q <= cw_q + 4'd1;
							st_q <= S_LOOP;
						end
					end
					S_WDATA: begin
						code_q <= pfx_rd_q;
						st_q   <= S_WCHK;
					end
					default: begin
						res_valid_q  <= 1'b1;
						res_status_q <= ST_PIXEL;
						res_pixel_q  <= stk_rd_q;
						res_last_q   <= (sc_q == '0);
						res_x_q      <= col_q;
						res_y_q      <= row_q;
						res_bad_q    <= bad_q;
						if (col_n == width_q) begin
							col_q <= '0;
							row_q <= row_q + 16'd1;
						end else begin
							col_q <= col_n;
						end
						st_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = res_status_q;
	assign pixel       = res_pixel_q;
	assign pos_x       = res_x_q;
	assign pos_y       = res_y_q;
	assign string_last = res_last_q;
	assign bad_codes   = res_bad_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q <= SW'(TABLE_DEPTH)) else $error("string stack overflow");
	a_width_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cw_q <= 4'(MCB) && cw_q > effm_q) else $error("code width out of range");
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_WDATA |-> $past(st_q) == S_WCHK) else $error("table read without request");
	a_min_size: assert property (@(posedge clk) disable iff (!arst_n)
		effm_q >= 4'd2 && (min_q < 4'd2 || effm_q <= min_q)) else $error("bad min size");

endmodule
`default_nettype wire

[rtl/gif_lzw_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid / in_stall    op, data_byte
// res      res_valid / res_stall  status, pixel, pos_x, pos_y, string_last, bad_codes
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A push word's result is registered in the cycle after it is taken.
// A pull that pops a waiting character passes the loop and pop states. A clear, an
// end or the first code after a clear is handled in the loop state; any other code
// also passes the check state, plus a data and check state pair per step of the
// chain walk, on the single registered read port of the prefix/suffix memories.
// Reset is asynchronous and clears all control state; the tables need no
// clearing pass, as a never-written entry is never legitimately read.
// A two-word input queue parts the front from the decoder, and the result
// register is refilled in the same cycle that the downstream side takes it.
module gif_lzw_decoder_unit #(
	parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
	parameter int TABLE_DEPTH   = gld_pkg::TABLE_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         op,
	input  wire  [7:0]  data_byte,
	output logic        res_valid,
	input  wire         res_stall,
	output logic [2:0]  status,
	output logic [7:0]  pixel,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic        string_last,
	output logic [15:0] bad_codes,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import gld_pkg::*;

	// Each word is classified as push or pull on its way into the queue.
	item_t q_item;
	logic  q_valid, q_take;

	// Registers accept a write in every cycle; the user must write them only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;

	gld_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_byte (data_byte),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take)
	);

	// The decoder unpacks codes, walks the string table and pops pixels.
	gld_core #(
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.TABLE_DEPTH   (TABLE_DEPTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_take      (q_take),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.status      (status),
		.pixel       (pixel),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.string_last (string_last),
		.bad_codes   (bad_codes)
	);

endmodule
`default_nettype wire
